>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the rate limiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define TBRL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TBRL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/tbrl_pkg.sv
// Shared types and constants of the token bucket rate limiter.
package tbrl_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned TOKEN_W = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned VERDICT_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_TDATA_W = 32;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [VERDICT_W-1:0] VERDICT_OK = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_FLOODING = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_KICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOKEN_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_KICK_THRESHOLD = 2'd1;

  // Tokens are unsigned Q8.8, so one token is 256.
  localparam logic [TOKEN_W-1:0] TOKEN_ONE = 16'd256;
  localparam logic [TOKEN_W-1:0] ALLOWANCE_RESET = 16'd1280;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [TOKEN_W-1:0] token_limit;
    logic [COUNT_W-1:0] kick_threshold;
  } cfg_t;

endpackage

>>> hw/rtl/tbrl_cfg_regs.sv
// Configuration registers of the rate limiter.
module tbrl_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [tbrl_pkg::TOKEN_W-1:0]   wr_data,
  output tbrl_pkg::cfg_t                 cfg
);

  tbrl_pkg::cfg_t cfg_r;
  tbrl_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        tbrl_pkg::CFG_IDX_TOKEN_LIMIT:    cfg_nxt.token_limit = wr_data;
        tbrl_pkg::CFG_IDX_KICK_THRESHOLD: cfg_nxt.kick_threshold = wr_data;
        default:                          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/tbrl_bucket.sv
// Bucket state and the combinational refill, spend and verdict logic.
module tbrl_bucket (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [tbrl_pkg::STAMP_W-1:0]   stamp,
  input  tbrl_pkg::cfg_t                 cfg,
  output logic [tbrl_pkg::VERDICT_W-1:0] verdict
);

  localparam int unsigned PROD_W = tbrl_pkg::STAMP_W + tbrl_pkg::TOKEN_W;
  localparam int unsigned GROW_W = PROD_W - 3;
  localparam int unsigned SUM_W = GROW_W + 1;

  logic [tbrl_pkg::STAMP_W-1:0] last_stamp_r, last_stamp_nxt;
  logic [tbrl_pkg::TOKEN_W-1:0] allowance_r, allowance_nxt;
  logic [tbrl_pkg::COUNT_W-1:0] denial_count_r, denial_count_nxt;

  logic [tbrl_pkg::STAMP_W-1:0] elapsed;
  logic [PROD_W-1:0]            product;
  logic [GROW_W-1:0]            growth;
  logic [SUM_W-1:0]             sum;
  logic [tbrl_pkg::TOKEN_W-1:0] capped;
  logic [tbrl_pkg::COUNT_W-1:0] count_inc;

  assign elapsed = stamp - last_stamp_r;
  assign product = {{tbrl_pkg::TOKEN_W{1'b0}}, elapsed}
                 * {{tbrl_pkg::STAMP_W{1'b0}}, cfg.token_limit};
  // Dividing by eight drops the three low bits of the product.
  assign growth = product[PROD_W-1:3];
  assign sum = {1'b0, growth} + {{(SUM_W - tbrl_pkg::TOKEN_W){1'b0}}, allowance_r};
  assign capped = (sum > {{(SUM_W - tbrl_pkg::TOKEN_W){1'b0}}, cfg.token_limit})
                ? cfg.token_limit : sum[tbrl_pkg::TOKEN_W-1:0];
  assign count_inc = (denial_count_r != tbrl_pkg::COUNT_MAX)
                   ? denial_count_r + 1'b1 : denial_count_r;

  always_comb begin
    last_stamp_nxt = last_stamp_r;
    allowance_nxt = allowance_r;
    denial_count_nxt = denial_count_r;
    verdict = tbrl_pkg::VERDICT_OK;
    if (step) begin
      last_stamp_nxt = stamp;
    end
    // A zero limit turns limiting off and leaves the allowance and count untouched.
    if (cfg.token_limit != '0) begin
      if (capped < tbrl_pkg::TOKEN_ONE) begin
        verdict = (count_inc > cfg.kick_threshold)
                ? tbrl_pkg::VERDICT_KICK : tbrl_pkg::VERDICT_FLOODING;
        if (step) begin
          allowance_nxt = capped;
          denial_count_nxt = count_inc;
        end
      end else begin
        if (step) begin
          allowance_nxt = capped - tbrl_pkg::TOKEN_ONE;
          denial_count_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r <= '0;
      allowance_r <= tbrl_pkg::ALLOWANCE_RESET;
      denial_count_r <= '0;
    end else begin
      last_stamp_r <= last_stamp_nxt;
      allowance_r <= allowance_nxt;
      denial_count_r <= denial_count_nxt;
    end
  end

endmodule

>>> hw/rtl/token_bucket_rate_limiter_top.sv
// A request transfer is first held in the input register; its verdict is stored in the output
// register once that register is empty or being drained, and is presented from there.
// Throughput: one request per cycle unless the output stalls; the input register feeds one
// pass of multiply, add, cap and compare into the output register, which updates the bucket.
// Reset (rst_n, synchronous, active low) empties both registers, clears the limits,
// zeroes the stamp and count and loads the allowance with five tokens.
module token_bucket_rate_limiter_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tbrl_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] now_seconds
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tbrl_pkg::OUT_TDATA_W-1:0] out_tdata,  // [1:0] verdict, [7:2] zero
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbrl_pkg::TOKEN_W-1:0]     cfg_data
);

  tbrl_pkg::cfg_t cfg;

  logic                           in_valid_r, in_valid_nxt;
  logic [tbrl_pkg::STAMP_W-1:0]   in_stamp_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [tbrl_pkg::VERDICT_W-1:0] verdict_r;
  logic [tbrl_pkg::VERDICT_W-1:0] verdict;
  logic                           out_free;
  logic                           step;

  assign cfg_ready = 1'b1;

  tbrl_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The output register takes a new verdict when empty or being drained.
  assign out_free = !out_valid_r || out_tready;
  assign step = in_valid_r && out_free;
  assign in_tready = !in_valid_r || step;

  tbrl_bucket u_bucket (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .stamp   (in_stamp_r),
    .cfg     (cfg),
    .verdict (verdict)
  );

  always_comb begin
    in_valid_nxt = in_tvalid || (in_valid_r && !step);
    out_valid_nxt = step || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_stamp_r <= in_tdata;
    end
    if (step) begin
      verdict_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {{(tbrl_pkg::OUT_TDATA_W - tbrl_pkg::VERDICT_W){1'b0}}, verdict_r};

endmodule

>>> hw/rtl/tbrl_checker.sv
// Port-level checker for the rate limiter, bound to the top level.
`include "assert_macros.svh"

module tbrl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tbrl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  `TBRL_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "stalled verdict dropped")
  `TBRL_ASSERT(a_verdict_legal, out_tvalid |-> out_tdata[1:0] != 2'd3 && out_tdata[7:2] == 6'd0, "illegal verdict code")
  `TBRL_ASSERT(a_latency, (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid, "verdict late")
  `TBRL_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind token_bucket_rate_limiter_top tbrl_checker u_tbrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
